// ===== rtl/shared_buffer_multi_queue_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the shared-buffer multi-queue
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication
`define SBMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbmq_pkg.sv =====
// ---------------------------------------------------------------------------
// sbmq_pkg
// Shared types and codes of the shared-buffer multi-queue.
// ---------------------------------------------------------------------------
package sbmq_pkg;

  localparam int DATA_W = 32;

  // Operation codes (in_tuser bit 0)
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // One result item
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
  } sbmq_res_t;

endpackage

// ===== rtl/sbmq_out_stage.sv =====
// ---------------------------------------------------------------------------
// sbmq_out_stage
// One-entry output register that decouples the sequencer from the receiver.
// ---------------------------------------------------------------------------
module sbmq_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  sbmq_pkg::sbmq_res_t push_res,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sbmq_pkg::sbmq_res_t out_res
);
  import sbmq_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  sbmq_res_t res_r;

  // Slot is free when empty or draining this cycle
  assign push_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push_valid && push_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      res_r <= push_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/shared_buffer_multi_queue.sv =====
// ---------------------------------------------------------------------------
// shared_buffer_multi_queue
// QUEUES FIFO queues sharing one ENTRIES-slot data buffer through a linked
// next-pointer memory and a free list.
// Input channel: in_tuser = {queue_id, op}, in_tdata = data_in. op 0 pushes
// data_in onto the queue, op 1 pops its head. Every transfer yields exactly
// one result: out_tdata = data_out, out_tuser = status (ok/overflow/
// underflow). data_out is zero except on a successful pop.
// Timing: one item at a time: accept (queue pointer read), link/data
// memory read (RD1), update and write-back (RD2). The result is registered
// and, in PUSH, moves into the output register; the next item is taken in
// the cycle the result moves into that register.
// Reset: all queues empty, free list full; no clearing pass (slots never
// handed out are drawn from a fill counter). If the receiver stalls, the
// output register holds the result, one more item is processed, and input
// stays stalled until the register frees up.
// ---------------------------------------------------------------------------
`include "shared_buffer_multi_queue_assert.svh"

module shared_buffer_multi_queue #(
  parameter int ENTRIES = 16,
  parameter int QUEUES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [2:0]  in_tuser,   // [0] op, [2:1] queue_id
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [1:0]  out_tuser   // [1:0] status
);
  import sbmq_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int EW = 2 * AW + 1;   // {nonempty, head, tail}

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic          in_acc;
  logic          st_ready;
  logic [2:0]    q_mod;
  logic [QW-1:0] q_in;

  // Captured item
  logic              op_r;
  logic [QW-1:0]     qid_r;
  logic [DATA_W-1:0] din_r;

  // Memories
  logic [EW-1:0]     q_mem    [QUEUES];
  logic [AW-1:0]     link_mem [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [QUEUES-1:0] qv_r, qv_nxt;
  logic [EW-1:0]     q_rd_r;
  logic              qv_hit_r;
  logic [AW-1:0]     link_rd_r;
  logic [DATA_W-1:0] data_rd_r;

  // Free list: recycled stack plus never-used fill region
  logic [AW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;

  // Decoded queue entry
  logic          q_ne;
  logic [AW-1:0] q_head, q_tail;
  logic [AW-1:0] link_raddr;

  // Write-back controls
  logic          q_we;
  logic [EW-1:0] q_wdata;
  logic          link_we;
  logic [AW-1:0] link_waddr, link_wdata;
  logic          data_we;
  logic [AW-1:0] slot;

  sbmq_res_t res_r, res_nxt;

  // Handshakes
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_PUSH) && st_ready);
  assign in_acc    = in_tvalid && in_tready;

  // Queue number modulo QUEUES (at most three subtractions on 3 bits)
  always_comb begin
    q_mod = {1'b0, in_tuser[2:1]};
    for (int k = 0; k < 3; k++) begin
      if (int'(q_mod) >= QUEUES) begin
        q_mod = q_mod - 3'(QUEUES);
      end
    end
    q_in = QW'(q_mod);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = S_PUSH;
      S_PUSH: begin
        if (st_ready) state_nxt = in_acc ? S_RD1 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser[0];
      qid_r <= q_in;
      din_r <= in_tdata;
    end
  end

  // Queue pointer memory: read at accept, written in RD2
  always_ff @(posedge clk) begin
    if (q_we) q_mem[qid_r] <= q_wdata;
    if (in_acc) begin
      q_rd_r   <= q_mem[q_in];
      qv_hit_r <= qv_r[q_in];
    end
  end

  // An entry never written reads as an empty queue
  assign q_ne   = qv_hit_r && q_rd_r[EW-1];
  assign q_head = q_rd_r[2*AW-1:AW];
  assign q_tail = q_rd_r[AW-1:0];

  // Link and data memories: read in RD1, written in RD2
  assign link_raddr = (op_r == OP_DEQ) ? q_head : free_head_r;

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (state_r == S_RD1) link_rd_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[slot] <= din_r;
    if (state_r == S_RD1) data_rd_r <= data_mem[q_head];
  end

  // Update and write-back
  always_comb begin
    free_head_nxt = free_head_r;
    rcnt_nxt      = rcnt_r;
    fresh_nxt     = fresh_r;
    qv_nxt        = qv_r;
    q_we          = 1'b0;
    q_wdata       = q_rd_r;
    link_we       = 1'b0;
    link_waddr    = q_tail;
    link_wdata    = free_head_r;
    data_we       = 1'b0;
    slot          = free_head_r;
    res_nxt       = res_r;
    if (state_r == S_RD2) begin
      res_nxt.data   = '0;
      res_nxt.status = ST_OK;
      if (op_r == OP_ENQ) begin
        // Take a recycled slot first, then a never-used one
        if (rcnt_r != '0) begin
          slot          = free_head_r;
          free_head_nxt = link_rd_r;
          rcnt_nxt      = rcnt_r - CW'(1);
        end else if (fresh_r < CW'(ENTRIES)) begin
          slot      = fresh_r[AW-1:0];
          fresh_nxt = fresh_r + CW'(1);
        end else begin
          res_nxt.status = ST_OVERFLOW;
        end
        if (res_nxt.status == ST_OK) begin
          data_we = 1'b1;
          q_we    = 1'b1;
          qv_nxt[qid_r] = 1'b1;
          if (q_ne) begin
            // Append behind the current tail
            link_we    = 1'b1;
            link_waddr = q_tail;
            link_wdata = slot;
            q_wdata    = {1'b1, q_head, slot};
          end else begin
            q_wdata = {1'b1, slot, slot};
          end
        end
      end else begin
        if (!q_ne) begin
          res_nxt.status = ST_UNDERFLOW;
        end else begin
          res_nxt.data = data_rd_r;
          q_we         = 1'b1;
          qv_nxt[qid_r] = 1'b1;
          // Last slot leaves the queue empty
          if (q_head == q_tail) begin
            q_wdata = {1'b0, q_head, q_tail};
          end else begin
            q_wdata = {1'b1, link_rd_r, q_tail};
          end
          // Push the freed slot onto the recycled stack
          link_we       = 1'b1;
          link_waddr    = q_head;
          link_wdata    = free_head_r;
          free_head_nxt = q_head;
          rcnt_nxt      = rcnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r        <= '0;
      rcnt_r      <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
    end else begin
      qv_r        <= qv_nxt;
      rcnt_r      <= rcnt_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Output register
  sbmq_res_t out_res;

  sbmq_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (state_r == S_PUSH),
    .push_res   (res_r),
    .push_ready (st_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.status;

  // Assertions
  `SBMQ_ASSERT_IMPL(a_recycled_bound, 1'b1, rcnt_r <= fresh_r, "recycled count exceeds used slots")
  `SBMQ_ASSERT_NEXT(a_accept_seq, in_acc, state_r == S_RD1, "accepted item did not start a read")
  `SBMQ_ASSERT_NEXT(a_push_lands, (state_r == S_PUSH) && st_ready, out_tvalid, "result lost at output")
  `SBMQ_ASSERT_NEXT(a_enq_recycled_ok, (state_r == S_RD2) && (op_r == OP_ENQ) && (rcnt_r != '0), res_r.status == ST_OK, "overflow with free slot")

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for shared_buffer_multi_queue. Enqueue and dequeue
// transfers go to the four queues, starting with a short directed run over
// the empty, full and just-emptied cases and then moving to random phases
// mostly biased toward filling or draining the shared buffer. Each accepted input
// updates a behavioral copy of the queue manager, which predicts data and
// status for the result it owes. The sender runs in bursts with gaps, and the
// receiver stalls on a pattern of its own, including one long hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  import sbmq_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int QUEUES     = 4;
  localparam int PTR_W      = $clog2(ENTRIES + 1);
  localparam int RAND_ITEMS = 1530;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYC   = 300;
  localparam int DRAIN_CYC  = 20;

  localparam logic [PTR_W-1:0] NIL_SLOT = PTR_W'(ENTRIES);

  // Queue manager model plus the list of results still due
  class queue_mgr_scoreboard;
    sbmq_res_t        due_results[$];
    logic [31:0]      slot_data [ENTRIES];
    logic [PTR_W-1:0] next_slot [ENTRIES];
    logic [PTR_W-1:0] head_slot [QUEUES];
    logic [PTR_W-1:0] tail_slot [QUEUES];
    logic [PTR_W-1:0] free_slot;
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_data[i] = '0;
        next_slot[i] = PTR_W'(i + 1);
      end
      for (int i = 0; i < QUEUES; i++) begin
        head_slot[i] = NIL_SLOT;
        tail_slot[i] = NIL_SLOT;
      end
      free_slot  = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted input to the model and queue the result it owes
    function void record_transfer(logic op, logic [1:0] qid, logic [31:0] din);
      sbmq_res_t        res;
      int               q;
      logic [PTR_W-1:0] s;
      res.data   = '0;
      res.status = ST_OK;
      q = int'(qid) % QUEUES;
      if (op == OP_ENQ) begin
        s = free_slot;
        if (s >= ENTRIES) begin
          res.status = ST_OVERFLOW;
        end else begin
          free_slot = next_slot[s];
          if (head_slot[q] >= ENTRIES) begin
            head_slot[q] = s;
          end else if (tail_slot[q] < ENTRIES) begin
            next_slot[tail_slot[q]] = s;
          end
          next_slot[s] = NIL_SLOT;
          tail_slot[q] = s;
          slot_data[s] = din;
        end
      end else begin
        s = head_slot[q];
        if (s >= ENTRIES) begin
          res.status = ST_UNDERFLOW;
        end else begin
          head_slot[q] = next_slot[s];
          // last slot gone: queue is empty again
          if (head_slot[q] >= ENTRIES) begin
            head_slot[q] = NIL_SLOT;
            tail_slot[q] = NIL_SLOT;
          end
          next_slot[s] = free_slot;
          free_slot    = s;
          res.data     = slot_data[s];
        end
      end
      due_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [31:0] dout, logic [1:0] st);
      sbmq_res_t exp_res;
      if (due_results.size() == 0) begin
        $error("result with nothing due: data_out=%h status=%0d", dout, st);
        mismatches++;
        return;
      end
      exp_res = due_results.pop_front();
      if (dout !== exp_res.data) begin
        $error("data_out: expected %h, got %h", exp_res.data, dout);
        mismatches++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] data_in
  logic [2:0]  in_tuser;   // [0] op, [2:1] queue_id
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] data_out
  logic [1:0]  out_tuser;  // [1:0] status

  queue_mgr_scoreboard scb;
  bit                  hold_req;
  int unsigned         burst_left;
  int unsigned         idle_cycles;

  shared_buffer_multi_queue #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    scb = new();
  end

  // Input monitor feeds the model
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      scb.record_transfer(in_tuser[0], in_tuser[2:1], in_tdata);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      scb.check_result(out_tdata, out_tuser);
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall mode picked at random for a random run length; long hold on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(1) == 0);
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // One input transfer, then maybe a gap at the end of a burst
  task automatic send_item(logic op, logic [1:0] qid, logic [31:0] din);
    in_tvalid <= 1'b1;
    in_tdata  <= din;
    in_tuser  <= {qid, op};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait for every due result; the first edge lets the
  // input monitor record the last transfer
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned enq_pct;
    logic [1:0]  focus_q;
    logic [1:0]  qid;
    logic        op;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    hold_req    = 1'b0;
    burst_left  = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, extreme values, emptied queue, full buffer
    send_item(OP_DEQ, 2'd0, $urandom);
    send_item(OP_ENQ, 2'd0, 32'h7fff_ffff);
    send_item(OP_ENQ, 2'd1, 32'h8000_0000);
    send_item(OP_ENQ, 2'd2, 32'h0000_0000);
    send_item(OP_ENQ, 2'd3, 32'hffff_ffff);
    send_item(OP_DEQ, 2'd3, $urandom);
    send_item(OP_DEQ, 2'd3, $urandom);
    send_item(OP_DEQ, 2'd1, $urandom);
    for (int i = 0; i < ENTRIES - 2; i++) begin
      send_item(OP_ENQ, 2'(i), $urandom);
    end
    send_item(OP_ENQ, 2'd1, $urandom);
    send_item(OP_DEQ, 2'd0, $urandom);
    wait_all_results();

    // Random phases, most biased toward filling or draining
    sent = 0;
    seg  = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(3))
        0: enq_pct = 20;
        1: enq_pct = 50;
        2: enq_pct = 80;
        default: enq_pct = 95;
      endcase
      focus_q = 2'($urandom_range(3));
      seg_len = $urandom_range(40, 120);
      if (seg == 3) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < seg_len && sent < RAND_ITEMS; i++) begin
        op  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        qid = ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : focus_q;
        send_item(op, qid, pick_value());
        sent++;
      end
      if (seg == 8) begin
        wait_all_results();
      end
      seg++;
    end

    wait_all_results();
    repeat (DRAIN_CYC) @(posedge clk);
    if (scb.mismatches == 0 && scb.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbmq_pkg.sv
rtl/sbmq_out_stage.sv
rtl/shared_buffer_multi_queue.sv
sim/tb_top.sv
